### rtl/keyframe_track_interpolator_unit_assert.svh
// Assertion macros for the keyframe track interpolator.
// Bodies are empty when SYNTHESIS is defined.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_UNIT_ASSERT_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KTI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define KTI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KTI_ASSERT(lbl, clk, rstn, prop, msg)
`define KTI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/kti_pkg.sv
// Shared constants and types for the keyframe track interpolator.
// No dependencies.
`timescale 1ns / 1ps
package kti_pkg;
  localparam int unsigned MaxKeysDef = 16;
  localparam int unsigned DvdW = 64;
  localparam int unsigned DivW = 32;

  localparam logic [1:0] ReqInsert  = 2'd0;
  localparam logic [1:0] ReqTick    = 2'd1;
  localparam logic [1:0] ReqEvalT   = 2'd2;
  localparam logic [1:0] ReqEvalPh  = 2'd3;

  localparam logic [2:0] AddrRun  = 3'd0;
  localparam logic [2:0] AddrLoop = 3'd4;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] time_ms;
  } key_t;
endpackage

### rtl/kti_key_mem.sv
// Key table memory: one write port, one registered read port.
// Uses kti_pkg::key_t.
`timescale 1ns / 1ps
module kti_key_mem #(
  parameter int unsigned DEPTH = kti_pkg::MaxKeysDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  kti_pkg::key_t     wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output kti_pkg::key_t     rdata_o
);
  kti_pkg::key_t mem_q [DEPTH];
  kti_pkg::key_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;
endmodule

### rtl/kti_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned 64 by 32.
// Uses kti_pkg widths.
`timescale 1ns / 1ps
module kti_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kti_pkg::DvdW-1:0]  dividend_i,
  input  logic [kti_pkg::DivW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [kti_pkg::DvdW-1:0]  quotient_o
);
  localparam int unsigned CntW = $clog2(kti_pkg::DvdW + 1);

  logic [kti_pkg::DvdW-1:0] dvd_q;
  logic [kti_pkg::DivW-1:0] rem_q, div_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q, done_q;
  logic [kti_pkg::DivW:0]   rem_sh;
  logic [kti_pkg::DivW+1:0] diff;
  logic                     ge;

  assign rem_sh = {rem_q, dvd_q[kti_pkg::DvdW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_q};
  assign ge     = ~diff[kti_pkg::DivW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      dvd_q  <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
      cnt_q  <= CntW'(kti_pkg::DvdW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[kti_pkg::DvdW-2:0], ge};
      rem_q <= ge ? diff[kti_pkg::DivW-1:0] : rem_sh[kti_pkg::DivW-1:0];
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

### rtl/keyframe_track_interpolator_unit.sv
// Keyframe track interpolator top level: sequencer, key table and playhead.
// Depends on kti_pkg, kti_key_mem, kti_divider and the assertion header.
// One request at a time. An insert into a full table goes straight to the
// result; otherwise an insert writes the new key directly (new key lands in
// slot 0) or first reads and compares entries, moving each later key up one
// slot (registered read, then write per entry). A tick goes straight to the
// result when paused or the table is empty, else it updates the playhead in
// S_TICK. An evaluate on an empty table goes straight to the result; otherwise
// it scans keys one per cycle and, when it interpolates, adds a multiply step,
// a step to start the divider and the bit-serial 64-bit divide. The result is
// registered, so the next request is taken while it waits; a finished request
// stalls only while an older result is not taken.
`timescale 1ns / 1ps
`include "keyframe_track_interpolator_unit_assert.svh"
module keyframe_track_interpolator_unit #(
  parameter int unsigned MAX_KEYS = kti_pkg::MaxKeysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // time_ms[31:0], key_value[63:32], step_ms[79:64]
  input  logic [79:0] s_axis_tdata,
  // req_type[1:0], discrete[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_value[31:0], playhead_ms[63:32], key_count[68:64], zero fill
  output logic [71:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);
  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_TICK, S_EV_WAIT, S_EV_CALC, S_EV_MUL,
    S_DIV_GO, S_DIV, S_FIN
  } state_e;

  state_e              state_q;
  logic                run_q, loop_q;
  logic [CW-1:0]       cnt_q, pos_q, k_q;
  logic [31:0]         ph_q, t_q, v_q, q_q;
  logic [15:0]         step_q;
  logic                disc_q;
  logic [31:0]         t1_q, v1_q, t2_q, v2_q, res_q;
  logic [31:0]         magq_q, magv_q, d_q;
  logic                neg_q;
  logic [63:0]         prod_q;
  kti_pkg::status_e    st_q;
  logic                ov_q;
  logic [31:0]         ores_q, oph_q;
  logic [4:0]          ocnt_q;
  kti_pkg::status_e    ost_q;

  logic                acc, cfg_wr;
  logic [1:0]          in_req;
  logic [CW-1:0]       cnt_m1, pos_m1, k_p1;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  kti_pkg::key_t       mem_wdata, rd;
  logic                ev_take;
  logic [31:0]         last_t;
  logic [32:0]         ph_sum, dq, dv;
  logic [31:0]         ph_tick;
  logic                div_start, div_busy, div_done;
  logic [63:0]         quot;
  logic [33:0]         sum;
  logic [31:0]         sum_sat;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;
  assign prdata        = {31'b0, (paddr == kti_pkg::AddrLoop) ? loop_q :
                                 (paddr == kti_pkg::AddrRun) ? run_q : 1'b0};
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign in_req        = s_axis_tuser[1:0];
  assign cnt_m1        = cnt_q - CW'(1);
  assign pos_m1        = pos_q - CW'(1);
  assign k_p1          = k_q + CW'(1);
  assign ev_take       = (k_q == '0) || (rd.time_ms <= q_q);

  kti_key_mem #(.DEPTH(MAX_KEYS), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  kti_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign div_start = (state_q == S_DIV_GO);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q[AW-1:0];
    mem_wdata = '{value: v_q, time_ms: t_q};
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (acc && in_req == kti_pkg::ReqTick && cnt_q != '0) begin
          mem_raddr = cnt_m1[AW-1:0];
        end
      end
      S_INS_RD: begin
        if (pos_q == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr = pos_m1[AW-1:0];
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rd.time_ms > t_q) begin
          mem_wdata = rd;
        end
      end
      S_EV_WAIT: begin
        if (ev_take && k_p1 != cnt_q) begin
          mem_raddr = k_p1[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign last_t  = (state_q == S_TICK) ? rd.time_ms : 32'd0;
  assign ph_sum  = {1'b0, ph_q} + {17'b0, step_q};
  always_comb begin
    if (ph_q > last_t) begin
      ph_tick = loop_q ? 32'd0 : ph_q;
    end else begin
      ph_tick = ph_sum[32] ? 32'hFFFF_FFFF : ph_sum[31:0];
    end
  end

  assign dq = {1'b0, q_q} - {1'b0, t1_q};
  assign dv = {v2_q[31], v2_q} - {v1_q[31], v1_q};

  assign sum = neg_q ? ({{2{v1_q[31]}}, v1_q} - {2'b00, quot[31:0]})
                     : ({{2{v1_q[31]}}, v1_q} + {2'b00, quot[31:0]});
  always_comb begin
    if (quot[63:32] != '0) begin
      sum_sat = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (sum[33:31] != 3'b000 && sum[33:31] != 3'b111) begin
      sum_sat = sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      run_q   <= 1'b0;
      loop_q  <= 1'b0;
      cnt_q   <= '0;
      pos_q   <= '0;
      k_q     <= '0;
      ph_q    <= '0;
      t_q     <= '0;
      v_q     <= '0;
      q_q     <= '0;
      step_q  <= '0;
      disc_q  <= 1'b0;
      t1_q    <= '0;
      v1_q    <= '0;
      t2_q    <= '0;
      v2_q    <= '0;
      res_q   <= '0;
      magq_q  <= '0;
      magv_q  <= '0;
      d_q     <= '0;
      neg_q   <= 1'b0;
      prod_q  <= '0;
      st_q    <= kti_pkg::StatOk;
      ov_q    <= 1'b0;
      ores_q  <= '0;
      oph_q   <= '0;
      ocnt_q  <= '0;
      ost_q   <= kti_pkg::StatOk;
    end else begin
      if (cfg_wr && paddr == kti_pkg::AddrRun) begin
        run_q <= pwdata[0];
      end
      if (cfg_wr && paddr == kti_pkg::AddrLoop) begin
        loop_q <= pwdata[0];
      end
      if (ov_q && m_axis_tready && state_q != S_FIN) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            t_q    <= s_axis_tdata[31:0];
            v_q    <= s_axis_tdata[63:32];
            step_q <= s_axis_tdata[79:64];
            disc_q <= s_axis_tuser[2];
            res_q  <= '0;
            st_q   <= kti_pkg::StatOk;
            k_q    <= '0;
            pos_q  <= cnt_q;
            q_q    <= (in_req == kti_pkg::ReqEvalT) ? s_axis_tdata[31:0] : ph_q;
            case (in_req)
              kti_pkg::ReqInsert: begin
                if (cnt_q >= CW'(MAX_KEYS)) begin
                  st_q    <= kti_pkg::StatFull;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_INS_RD;
                end
              end
              kti_pkg::ReqTick: begin
                if (!run_q) begin
                  state_q <= S_FIN;
                end else if (cnt_q == '0) begin
                  if (ph_q > 32'd0) begin
                    if (loop_q) ph_q <= '0;
                  end else begin
                    ph_q <= {16'b0, s_axis_tdata[79:64]};
                  end
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_TICK;
                end
              end
              default: begin
                if (cnt_q == '0) begin
                  st_q    <= kti_pkg::StatEmpty;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_EV_WAIT;
                end
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (pos_q == '0) begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_FIN;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd.time_ms > t_q) begin
            pos_q   <= pos_m1;
            state_q <= S_INS_RD;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_FIN;
          end
        end
        S_TICK: begin
          ph_q    <= ph_tick;
          state_q <= S_FIN;
        end
        S_EV_WAIT: begin
          if (ev_take) begin
            t1_q <= rd.time_ms;
            v1_q <= rd.value;
            if (k_p1 == cnt_q) begin
              t2_q    <= rd.time_ms;
              v2_q    <= rd.value;
              state_q <= S_EV_CALC;
            end else begin
              k_q <= k_p1;
            end
          end else begin
            t2_q    <= rd.time_ms;
            v2_q    <= rd.value;
            state_q <= S_EV_CALC;
          end
        end
        S_EV_CALC: begin
          magq_q <= dq[32] ? 32'(-dq) : dq[31:0];
          magv_q <= dv[32] ? 32'(-dv) : dv[31:0];
          neg_q  <= dq[32] ^ dv[32];
          d_q    <= t2_q - t1_q;
          if (disc_q) begin
            res_q   <= v1_q;
            state_q <= S_FIN;
          end else if (t2_q == t1_q) begin
            res_q   <= v2_q;
            state_q <= S_FIN;
          end else begin
            state_q <= S_EV_MUL;
          end
        end
        S_EV_MUL: begin
          prod_q  <= {32'b0, magq_q} * {32'b0, magv_q};
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_q   <= sum_sat;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!ov_q || m_axis_tready) begin
            ov_q    <= 1'b1;
            ores_q  <= res_q;
            oph_q   <= ph_q;
            ocnt_q  <= 5'(cnt_q);
            ost_q   <= st_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b000, ocnt_q, oph_q, ores_q};
  assign m_axis_tuser  = ost_q;

  `KTI_ASSERT_ALWAYS(a_cnt_max, clk_i, cnt_q <= CW'(MAX_KEYS),
    "key count above table size")
  `KTI_ASSERT(a_cnt_step, clk_i, rst_ni,
    cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + CW'(1),
    "key count moved by more than one")
  `KTI_ASSERT(a_div_busy, clk_i, rst_ni, div_busy |-> state_q == S_DIV,
    "divider busy outside divide step")
  `KTI_ASSERT(a_acc_busy, clk_i, rst_ni, acc |=> !s_axis_tready,
    "request taken while previous in work")
endmodule
